// ===== hw/rtl/dvpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dvpd_pkg: shared types and constants
// Widths, register indexes and sequencer states of the dual velocity PID drive.
// ----------------------------------------------------------------------------
`default_nettype none

package dvpd_pkg;

    localparam int FRAC_BITS_DEF = 12;

    // serial multiplier operand widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 16;
    // serial divider widths
    localparam int DIV_N_W = 34;
    localparam int DIV_D_W = 11;

    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 19;
    localparam int ACC_W   = 16;
    localparam int TERM_W  = 48;
    localparam int STEER_W = 18;

    localparam logic [MUL_B_W-1:0] STEER_SCALE = 16'd9000;
    localparam logic [9:0]  RATE_RESET  = 10'd50;
    localparam logic [14:0] LIMIT_RESET = 15'd24000;

    // configuration register indexes
    localparam logic [3:0] REG_LIN_P = 4'd0;
    localparam logic [3:0] REG_LIN_I = 4'd1;
    localparam logic [3:0] REG_LIN_D = 4'd2;
    localparam logic [3:0] REG_ANG_P = 4'd3;
    localparam logic [3:0] REG_ANG_I = 4'd4;
    localparam logic [3:0] REG_ANG_D = 4'd5;
    localparam logic [3:0] REG_RATE  = 4'd6;
    localparam logic [3:0] REG_LIMIT = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_IM,
        ST_IDIV,
        ST_DM1,
        ST_DM2,
        ST_SUM,
        ST_STEER,
        ST_OUT
    } dvpd_state_t;

    // start / done pair of a serial arithmetic unit
    typedef struct packed {
        logic start;
    } dvpd_req_t;

    typedef struct packed {
        logic done;
    } dvpd_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dvpd_mul.sv =====
// ----------------------------------------------------------------------------
// dvpd_mul: bit-serial unsigned multiplier
// Shift-add over one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dvpd_mul
    import dvpd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dvpd_req_t          req,
    input  wire logic [MUL_A_W-1:0] a_in,
    input  wire logic [MUL_B_W-1:0] b_in,
    output dvpd_rsp_t               rsp,
    output logic      [MUL_A_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [MUL_A_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // one partial product per cycle
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = a_in;
            b_next    = b_in;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign product  = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dvpd_div.sv =====
// ----------------------------------------------------------------------------
// dvpd_div: bit-serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dvpd_div
    import dvpd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dvpd_req_t          req,
    input  wire logic [DIV_N_W-1:0] num_in,
    input  wire logic [DIV_D_W-1:0] den_in,
    output dvpd_rsp_t               rsp,
    output logic      [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] num_reg, num_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W+1:0] trial;

    // trial subtract of the shifted remainder
    always_comb begin
        shifted   = {rem_reg, num_reg[DIV_N_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            num_next  = num_in;
            den_next  = den_in;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_D_W+1]) begin
                rem_next = trial[DIV_D_W-1:0];
                num_next = {num_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_D_W-1:0];
                num_next = {num_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_velocity_pid_drive.sv =====
// ----------------------------------------------------------------------------
// dual_velocity_pid_drive: two incremental velocity-form PID loops
// Sequences a shared bit-serial multiplier and divider through the P, I and D
// terms of the linear and angular loops, then the steering scale.
// ----------------------------------------------------------------------------
//  channel   dir  fields (tdata low bit up)                            tuser
//  s_        in   lin_target, lin_measured, ang_target, ang_measured   enable
//  m_        out  lin_drive, ang_drive, steer_command, lin_p/i/d_term  -
//  cfg_      in   write enable, register index, data                   -
//
//  A tick runs, per loop, four serial multiplies and one serial divide, each with a
//  launch and a done step, then a sum step; after both loops come the steering
//  multiply and the output step, which raises m_tvalid and s_tready together.
//  s_tready is high only while the sequencer idles; a finished result waits in
//  the output register, so the next tick is taken while m_tready is low.
//  Reset is synchronous, active low; it clears past errors, accumulators, gains.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_velocity_pid_drive
    import dvpd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // lin_target, lin_measured, ang_target, ang_measured
    input  wire logic [63:0]  s_tdata,
    // enable
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // lin_drive, ang_drive, steer_command, lin_p_term, lin_i_term, lin_d_term
    output logic      [199:0] m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [3:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata
);

    localparam logic [TERM_W-1:0] FRAC_MASK = (TERM_W'(1) << FRAC_BITS) - TERM_W'(1);

    dvpd_state_t state_reg, state_next;
    logic        go_reg, go_next;
    logic        loop_sel_reg;

    // configuration
    logic [15:0] kp_reg [2];
    logic [15:0] ki_reg [2];
    logic [15:0] kd_reg [2];
    logic [9:0]  rate_reg;
    logic [14:0] limit_reg;

    // loop state
    logic signed [ERR_W-1:0] e_reg     [2];
    logic signed [ERR_W-1:0] e1_reg    [2];
    logic signed [ERR_W-1:0] e2_reg    [2];
    logic signed [ACC_W-1:0] accum_reg [2];
    logic signed [15:0]      at_reg;
    logic                    en_reg;

    // term magnitudes and linear terms
    logic [TERM_W-1:0]        p_mag_reg, i_mag_reg, d_mag_reg, steer_mag_reg;
    logic signed [TERM_W-1:0] lp_reg, li_reg, ld_reg;

    // serial units
    dvpd_req_t          mul_req, div_req;
    dvpd_rsp_t          mul_rsp, div_rsp;
    logic [MUL_A_W-1:0] mul_a, mul_p;
    logic [MUL_B_W-1:0] mul_b;
    logic [DIV_N_W-1:0] div_q;
    logic [DIV_D_W-1:0] div_den;

    logic                     accept;
    logic                     out_free;
    logic [9:0]               rate_eff;
    logic signed [DIFF_W-1:0] dp, si, dd;
    logic [DIFF_W-1:0]        dp_mag, si_mag, dd_mag;
    logic [15:0]              at_mag;
    logic signed [TERM_W-1:0] p_s, i_s, d_s, sum_s, q_s;
    logic signed [TERM_W:0]   u_s, lim_s;
    logic signed [ACC_W-1:0]  u_clamp;
    logic [TERM_W-1:0]        steer_shift;
    logic signed [TERM_W-1:0] steer_s;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign rate_eff = (rate_reg == 10'd0) ? 10'd1 : rate_reg;
    assign div_den  = {rate_eff, 1'b0};

    // error differences of the selected loop
    always_comb begin
        dp = DIFF_W'(e_reg[loop_sel_reg]) - DIFF_W'(e1_reg[loop_sel_reg]);
        si = DIFF_W'(e_reg[loop_sel_reg]) + DIFF_W'(e1_reg[loop_sel_reg]);
        dd = DIFF_W'(e_reg[loop_sel_reg]) - (DIFF_W'(e1_reg[loop_sel_reg]) <<< 1)
             + DIFF_W'(e2_reg[loop_sel_reg]);
        dp_mag = dp[DIFF_W-1] ? DIFF_W'(-dp) : DIFF_W'(dp);
        si_mag = si[DIFF_W-1] ? DIFF_W'(-si) : DIFF_W'(si);
        dd_mag = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
        at_mag = at_reg[15] ? 16'(-at_reg) : 16'(at_reg);
    end

    // signed terms, scaled sum and clamp, signed steering command
    always_comb begin
        p_s   = dp[DIFF_W-1] ? -$signed(p_mag_reg) : $signed(p_mag_reg);
        i_s   = si[DIFF_W-1] ? -$signed(i_mag_reg) : $signed(i_mag_reg);
        d_s   = dd[DIFF_W-1] ? -$signed(d_mag_reg) : $signed(d_mag_reg);
        sum_s = p_s + i_s + d_s;
        q_s   = (sum_s + (sum_s[TERM_W-1] ? $signed(FRAC_MASK) : $signed(TERM_W'(0))))
                >>> FRAC_BITS;
        u_s   = (TERM_W+1)'(accum_reg[loop_sel_reg]) + (TERM_W+1)'(q_s);
        lim_s = $signed({{(TERM_W-14){1'b0}}, limit_reg});
        if (u_s > lim_s) begin
            u_clamp = ACC_W'(lim_s);
        end else if (u_s < -lim_s) begin
            u_clamp = ACC_W'(-lim_s);
        end else begin
            u_clamp = ACC_W'(u_s);
        end
        steer_shift = steer_mag_reg >> FRAC_BITS;
        steer_s     = at_reg[15] ? -$signed(steer_shift) : $signed(steer_shift);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid)     state_next = ST_P;
            ST_P:     if (mul_rsp.done) state_next = ST_IM;
            ST_IM:    if (mul_rsp.done) state_next = ST_IDIV;
            ST_IDIV:  if (div_rsp.done) state_next = ST_DM1;
            ST_DM1:   if (mul_rsp.done) state_next = ST_DM2;
            ST_DM2:   if (mul_rsp.done) state_next = ST_SUM;
            ST_SUM:   state_next = loop_sel_reg ? ST_STEER : ST_P;
            ST_STEER: if (mul_rsp.done) state_next = ST_OUT;
            ST_OUT:   if (out_free)     state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        go_next = (state_next != state_reg);
    end

    // unit launches and operand selection
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        mul_req.start = 1'b0;
        div_req.start = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_P: begin
                mul_req.start = go_reg;
                mul_a         = MUL_A_W'(dp_mag);
                mul_b         = kp_reg[loop_sel_reg];
            end
            ST_IM: begin
                mul_req.start = go_reg;
                mul_a         = MUL_A_W'(si_mag);
                mul_b         = ki_reg[loop_sel_reg];
            end
            ST_IDIV: begin
                div_req.start = go_reg;
            end
            ST_DM1: begin
                mul_req.start = go_reg;
                mul_a         = MUL_A_W'(dd_mag);
                mul_b         = kd_reg[loop_sel_reg];
            end
            ST_DM2: begin
                mul_req.start = go_reg;
                mul_a         = d_mag_reg;
                mul_b         = MUL_B_W'(rate_eff);
            end
            ST_STEER: begin
                mul_req.start = go_reg;
                mul_a         = MUL_A_W'(at_mag);
                mul_b         = STEER_SCALE;
            end
            default: begin
            end
        endcase
    end

    dvpd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .rsp     (mul_rsp),
        .product (mul_p)
    );

    dvpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .num_in   (i_mag_reg[DIV_N_W-1:0]),
        .den_in   (div_den),
        .rsp      (div_rsp),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                kp_reg[k] <= '0;
                ki_reg[k] <= '0;
                kd_reg[k] <= '0;
            end
            rate_reg  <= RATE_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LIN_P: kp_reg[0] <= cfg_wdata;
                REG_LIN_I: ki_reg[0] <= cfg_wdata;
                REG_LIN_D: kd_reg[0] <= cfg_wdata;
                REG_ANG_P: kp_reg[1] <= cfg_wdata;
                REG_ANG_I: ki_reg[1] <= cfg_wdata;
                REG_ANG_D: kd_reg[1] <= cfg_wdata;
                REG_RATE:  rate_reg  <= cfg_wdata[9:0];
                REG_LIMIT: limit_reg <= cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            loop_sel_reg <= 1'b0;
            m_tvalid     <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                e1_reg[k]    <= '0;
                e2_reg[k]    <= '0;
                accum_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            // result valid: set by the output cycle, cleared by a transfer
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_SUM: begin
                    accum_reg[loop_sel_reg] <= en_reg ? u_clamp : '0;
                    loop_sel_reg            <= 1'b1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        loop_sel_reg <= 1'b0;
                        for (int k = 0; k < 2; k++) begin
                            e2_reg[k] <= en_reg ? e1_reg[k] : '0;
                            e1_reg[k] <= e_reg[k];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            e_reg[0] <= ERR_W'($signed(s_tdata[15:0])) - ERR_W'($signed(s_tdata[31:16]));
            e_reg[1] <= ERR_W'($signed(s_tdata[47:32])) - ERR_W'($signed(s_tdata[63:48]));
            at_reg   <= s_tdata[47:32];
            en_reg   <= s_tuser;
        end
        if (mul_rsp.done) begin
            unique case (state_reg)
                ST_P:     p_mag_reg     <= mul_p;
                ST_IM:    i_mag_reg     <= mul_p;
                ST_DM1:   d_mag_reg     <= mul_p;
                ST_DM2:   d_mag_reg     <= mul_p;
                ST_STEER: steer_mag_reg <= mul_p;
                default: begin
                end
            endcase
        end
        if (div_rsp.done) begin
            i_mag_reg <= TERM_W'(div_q);
        end
        if (state_reg == ST_SUM && !loop_sel_reg) begin
            lp_reg <= p_s;
            li_reg <= i_s;
            ld_reg <= d_s;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata <= {6'd0, ld_reg, li_reg, lp_reg,
                        en_reg ? steer_s[STEER_W-1:0] : STEER_W'(0),
                        accum_reg[1], accum_reg[0]};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dvpd_checker.sv =====
// ----------------------------------------------------------------------------
// dvpd_checker: port-level checks
// Watches the stream ports of the drive block over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dvpd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [199:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one tick at a time: input closes after a transfer
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after a transfer");

    // a new result appears only while a tick is in work
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a tick in work");

    // clamped drive never reaches the most negative code
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000)
        else $error("drive outside clamp");

endmodule

bind dual_velocity_pid_drive dvpd_checker u_dvpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/dual_velocity_pid_drive_test.sv =====
// ----------------------------------------------------------------------------
// dual_velocity_pid_drive_test: self-checking bench of the dual PID drive
// Drives control ticks with random stalls on both channels, predicts each
// result from its own copy of the loop state and gains, and checks every
// result field. Covers directed corner cases and random ticks under
// several gain, rate and limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_velocity_pid_drive_test
    import dvpd_pkg::*;
();

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] lin_drive;
        logic signed [15:0] ang_drive;
        logic signed [17:0] steer;
        logic signed [47:0] p_term;
        logic signed [47:0] i_term;
        logic signed [47:0] d_term;
    } drive_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [3:0]   cfg_addr = '0;
    logic [15:0]  cfg_wdata = '0;

    // predictor copy of gains and loop state
    longint kp_lin, ki_lin, kd_lin, kp_ang, ki_ang, kd_ang, rate_hz, limit;
    longint lin_e1, lin_e2, ang_e1, ang_e2, lin_acc, ang_acc;

    drive_result_t expected_drives[$];
    int  errors = 0;
    int  ticks_sent = 0;
    int  results_seen = 0;
    int  settings_used = 0;
    bit  quiet = 1'b0;
    int  stall_cycles = 0;

    dual_velocity_pid_drive dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // one velocity-form loop: returns new clamped accumulator
    function automatic longint pid_step(input longint e, e1, e2, acc, kp, ki, kd,
                                        rate, lim, output longint pt, it, dt);
        longint u;
        pt = kp * (e - e1);
        it = (ki * (e + e1)) / (2 * rate);
        dt = kd * (e - 2 * e1 + e2) * rate;
        u = acc + (pt + it + dt) / (64'sd1 << FRAC_BITS_DEF);
        if (u > lim) u = lim;
        if (u < -lim) u = -lim;
        return u;
    endfunction

    task automatic predict_tick(input logic [63:0] data, input logic en);
        longint lt, lm, at, am, le, ae, r, lp, li, ld, ap, ai, ad, steer;
        drive_result_t res;
        lt = $signed(data[15:0]);
        lm = $signed(data[31:16]);
        at = $signed(data[47:32]);
        am = $signed(data[63:48]);
        le = lt - lm;
        ae = at - am;
        r = (rate_hz == 0) ? 1 : rate_hz;
        lin_acc = pid_step(le, lin_e1, lin_e2, lin_acc, kp_lin, ki_lin, kd_lin,
                           r, limit, lp, li, ld);
        ang_acc = pid_step(ae, ang_e1, ang_e2, ang_acc, kp_ang, ki_ang, kd_ang,
                           r, limit, ap, ai, ad);
        if (en) begin
            steer = (at * 9000) / (64'sd1 << FRAC_BITS_DEF);
            lin_e2 = lin_e1;
            ang_e2 = ang_e1;
        end else begin
            steer = 0;
            lin_acc = 0;
            ang_acc = 0;
            lin_e2 = 0;
            ang_e2 = 0;
        end
        lin_e1 = le;
        ang_e1 = ae;
        res.lin_drive = lin_acc[15:0];
        res.ang_drive = ang_acc[15:0];
        res.steer = steer[17:0];
        res.p_term = lp[47:0];
        res.i_term = li[47:0];
        res.d_term = ld[47:0];
        expected_drives.push_back(res);
    endtask

    // register write; only called with no tick in flight
    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(posedge aclk);
        case (idx)
            REG_LIN_P: kp_lin = val;
            REG_LIN_I: ki_lin = val;
            REG_LIN_D: kd_lin = val;
            REG_ANG_P: kp_ang = val;
            REG_ANG_I: ki_ang = val;
            REG_ANG_D: kd_ang = val;
            REG_RATE:  rate_hz = val[9:0];
            REG_LIMIT: limit = val[14:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_all(input logic [15:0] lp, li, ld, ap, ai, ad, rt, lm);
        write_reg(REG_LIN_P, lp);
        write_reg(REG_LIN_I, li);
        write_reg(REG_LIN_D, ld);
        write_reg(REG_ANG_P, ap);
        write_reg(REG_ANG_I, ai);
        write_reg(REG_ANG_D, ad);
        write_reg(REG_RATE, rt);
        write_reg(REG_LIMIT, lm);
        settings_used++;
    endtask

    // one tick transfer on the input channel, with an optional idle burst first
    task automatic send_tick(input logic [15:0] lt, lm, at, am, input logic en);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(17, 1);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {am, at, lm, lt};
        s_tuser = en;
        do @(posedge aclk); while (!s_tready);
        predict_tick(s_tdata, en);
        ticks_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (expected_drives.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    // result stall driver
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
            stall_cycles <= $urandom_range(16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [47:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        drive_result_t exp_r;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (expected_drives.size() == 0) begin
                errors++;
                $display("%0t unexpected result transfer: %h", $time, m_tdata);
            end else begin
                exp_r = expected_drives.pop_front();
                check_field("lin_drive", 48'(exp_r.lin_drive),
                            48'($signed(m_tdata[15:0])));
                check_field("ang_drive", 48'(exp_r.ang_drive),
                            48'($signed(m_tdata[31:16])));
                check_field("steer_command", 48'(exp_r.steer),
                            48'($signed(m_tdata[49:32])));
                check_field("lin_p_term", exp_r.p_term, m_tdata[97:50]);
                check_field("lin_i_term", exp_r.i_term, m_tdata[145:98]);
                check_field("lin_d_term", exp_r.d_term, m_tdata[193:146]);
            end
        end
    end

    // watchdog: cycles with work pending but no transfer
    int idle_count = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || !(s_tvalid || expected_drives.size() != 0)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // reset values: zero gains give zero terms, steering still active
    task automatic test_reset_defaults();
        send_tick(16'h1000, 16'h0800, 16'h2000, 16'h0000, 1'b1);
        send_tick(16'hE000, 16'h0000, 16'hE000, 16'h1000, 1'b1);
        drain();
    endtask

    // field extremes with full-scale gains, both clamp directions
    task automatic test_extremes();
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'd1000, 16'd32767);
        send_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        send_tick(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
        send_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_tick(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 1'b1);
        drain();
        set_all(16'd300, 16'd500, 16'd20, 16'd300, 16'd500, 16'd20, 16'd1, 16'd0);
        send_tick(16'h4000, 16'h0000, 16'hC000, 16'h0000, 1'b1);
        send_tick(16'h4000, 16'h1000, 16'hC000, 16'h1000, 1'b1);
        drain();
    endtask

    // disabled ticks clear drives and older errors, keep current errors
    task automatic test_disable();
        set_all(16'd900, 16'd4000, 16'd3, 16'd700, 16'd5000, 16'd2, 16'd50, 16'd24000);
        send_tick(16'h3000, 16'h0000, 16'h1000, 16'h0000, 1'b1);
        send_tick(16'h3000, 16'h0400, 16'h1000, 16'h0200, 1'b1);
        send_tick(16'h2000, 16'h0800, 16'hF000, 16'h0000, 1'b0);
        send_tick(16'h2000, 16'h0800, 16'hF000, 16'h0000, 1'b0);
        send_tick(16'h1000, 16'h0000, 16'h0800, 16'h0000, 1'b1);
        send_tick(16'h1000, 16'h0100, 16'h0800, 16'h0100, 1'b1);
        drain();
    endtask

    // rate of zero behaves as one
    task automatic test_zero_rate();
        write_reg(REG_RATE, 16'd0);
        send_tick(16'h1234, 16'h0100, 16'h0F00, 16'hFF00, 1'b1);
        send_tick(16'h0100, 16'h1234, 16'hFF00, 16'h0F00, 1'b1);
        drain();
    endtask

    // writes to unused indexes must not disturb any gain
    task automatic test_unused_index();
        write_reg(4'd8, 16'hFFFF);
        write_reg(4'd15, 16'h1234);
        write_reg(4'd11, 16'h0000);
        send_tick(16'h0800, 16'h0000, 16'h0800, 16'h0000, 1'b1);
        drain();
    endtask

    // random ticks over several random settings
    task automatic test_random(input int phases, input int per_phase);
        logic [15:0] base_l, base_a;
        logic en;
        for (int ph = 0; ph < phases; ph++) begin
            set_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                    pick_gain(),
                    (ph % 3 == 0) ? 16'($urandom_range(1000)) : 16'($urandom),
                    (ph % 4 == 1) ? 16'h7FFF : 16'($urandom));
            if (ph == phases - 1) quiet = 1'b1;
            base_l = 16'($urandom);
            base_a = 16'($urandom);
            en = 1'b1;
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(15) == 0) en = ~en;
                if ($urandom_range(4) == 0) begin
                    send_tick(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 1'($urandom));
                end else begin
                    // slowly varying signals, as in a real control loop
                    base_l = base_l + 16'($signed($urandom_range(512)) - 256);
                    base_a = base_a + 16'($signed($urandom_range(512)) - 256);
                    send_tick(base_l, base_l + 16'($urandom_range(2047)) - 16'd1024,
                              base_a, base_a + 16'($urandom_range(2047)) - 16'd1024, en);
                end
            end
            drain();
        end
    endtask

    initial begin
        kp_lin = 0; ki_lin = 0; kd_lin = 0;
        kp_ang = 0; ki_ang = 0; kd_ang = 0;
        rate_hz = 50; limit = 24000;
        lin_e1 = 0; lin_e2 = 0; ang_e1 = 0; ang_e2 = 0;
        lin_acc = 0; ang_acc = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_extremes();
        test_disable();
        test_zero_rate();
        test_unused_index();
        test_random(6, 150);

        repeat (400) @(posedge aclk);
        $display("Covered %0d ticks and %0d results over %0d register settings,",
                 ticks_sent, results_seen, settings_used);
        $display("including disabled ticks, zero rate, clamps and unused indexes.");
        if (errors == 0 && expected_drives.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
